// File: hdl/osc_pkg.sv
// Shared types and constants for the oversampled channel scaler.
// No dependencies; used by every module of the block.
package osc_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int CAL_W     = 16;
   localparam int VALUE_W   = 20;
   localparam int TOTAL_W   = 32;
   localparam int COUNT_W   = 16;
   localparam int CHAN_W    = 3;
   localparam int NUM_CAL   = 7;
   localparam int EXTRA_CH  = 3;
   localparam int PERCENT   = 100;

   localparam logic [CAL_W-1:0]   CAL_RESET   = 16'd100;
   localparam logic [CAL_W-1:0]   LEVEL_RESET = 16'd0;
   localparam logic [VALUE_W-1:0] VALUE_MAX   = 20'hFFFFF;

   typedef enum logic [2:0] {
      CSR_CAL_CELL0    = 3'd0,
      CSR_CAL_CELL1    = 3'd1,
      CSR_CAL_CELL2    = 3'd2,
      CSR_CAL_CELL3    = 3'd3,
      CSR_CAL_CURRENT  = 3'd4,
      CSR_CAL_BATT     = 3'd5,
      CSR_CAL_INPUT    = 3'd6,
      CSR_CELL_PRESENT = 3'd7
   } csr_reg_type;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_CLEAR  = 1'b1
   } action_type;

   typedef enum logic {
      TOK_RESULT = 1'b0,
      TOK_CLEAR  = 1'b1
   } tok_kind_type;

   typedef struct packed {
      logic         valid;
      tok_kind_type kind;
   } tok_ctl_type;

endpackage

// File: hdl/osc_seq.sv
// Sample accumulator and channel sequencer: sums samples per channel and
// issues a result or clear token with the channel gain. Uses osc_pkg.
module osc_seq #(
   parameter int SAMPLES_PER_CHANNEL = 16,
   parameter int CELL_CHANNELS       = 4,
   parameter int SAMPLE_BITS         = 10,
   parameter int SUM_W               = 14,
   parameter int CH_W                = 3
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  osc_pkg::action_type                            in_action,
   input  logic [osc_pkg::SAMPLE_W-1:0]                   in_sample,
   input  logic [osc_pkg::NUM_CAL-1:0][osc_pkg::CAL_W-1:0] cal,
   output osc_pkg::tok_ctl_type                           tok_out,
   input  logic                                           tok_ready,
   output logic [SUM_W-1:0]                               sum_out,
   output logic [CH_W-1:0]                                ch_out,
   output logic [osc_pkg::CAL_W-1:0]                      gain_out
);

   localparam int NUM_CH    = CELL_CHANNELS + osc_pkg::EXTRA_CH;
   localparam int IDX_W     = $clog2(SAMPLES_PER_CHANNEL + 1);
   localparam int MASK_BITS = (SAMPLE_BITS < osc_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : osc_pkg::SAMPLE_W;
   localparam logic [osc_pkg::SAMPLE_W-1:0] MASK =
      osc_pkg::SAMPLE_W'((1 << MASK_BITS) - 1);

   logic [SUM_W-1:0]           sum_ff, sum_in, sum_next;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [CH_W-1:0]            ch_ff, ch_in, ch_next;
   osc_pkg::tok_ctl_type       tok_ff, tok_in;
   logic [SUM_W-1:0]           sumo_ff, sumo_in;
   logic [CH_W-1:0]            cho_ff, cho_in;
   logic [osc_pkg::CAL_W-1:0]  gaino_ff, gaino_in;
   osc_pkg::csr_reg_type       gsel;
   logic                       accept;
   logic                       last;

   assign in_ready = !tok_ff.valid || tok_ready;
   assign accept   = in_valid && in_ready;
   assign sum_next = sum_ff + SUM_W'(in_sample & MASK);
   assign last     = (idx_ff == IDX_W'(SAMPLES_PER_CHANNEL - 1));
   assign ch_next  = (ch_ff == CH_W'(NUM_CH - 1)) ? '0 : ch_ff + 1'b1;

   // cells beyond the fourth share the last cell gain
   always_comb begin
      if (ch_ff < CH_W'(CELL_CHANNELS)) begin
         gsel = (ch_ff < CH_W'(3)) ? osc_pkg::csr_reg_type'(3'(ch_ff))
                                   : osc_pkg::CSR_CAL_CELL3;
      end else if (ch_ff == CH_W'(CELL_CHANNELS)) begin
         gsel = osc_pkg::CSR_CAL_CURRENT;
      end else if (ch_ff == CH_W'(CELL_CHANNELS + 1)) begin
         gsel = osc_pkg::CSR_CAL_BATT;
      end else begin
         gsel = osc_pkg::CSR_CAL_INPUT;
      end
   end

   always_comb begin
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      tok_in.valid = tok_ff.valid && !tok_ready;
      tok_in.kind  = tok_ff.kind;
      sumo_in      = sumo_ff;
      cho_in       = cho_ff;
      gaino_in     = gaino_ff;
      if (accept) begin
         if (in_action == osc_pkg::ACT_CLEAR) begin
            tok_in.valid = 1'b1;
            tok_in.kind  = osc_pkg::TOK_CLEAR;
         end else if (last) begin
            tok_in.valid = 1'b1;
            tok_in.kind  = osc_pkg::TOK_RESULT;
            sumo_in      = sum_next;
            cho_in       = ch_ff;
            gaino_in     = cal[gsel];
            sum_in       = '0;
            idx_in       = '0;
            ch_in        = ch_next;
         end else begin
            sum_in = sum_next;
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
         ch_ff  <= '0;
         tok_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
         ch_ff  <= ch_in;
         tok_ff <= tok_in;
      end
      sumo_ff  <= sumo_in;
      cho_ff   <= cho_in;
      gaino_ff <= gaino_in;
   end

   assign tok_out  = tok_ff;
   assign sum_out  = sumo_ff;
   assign ch_out   = cho_ff;
   assign gain_out = gaino_ff;

endmodule

// File: hdl/osc_scale.sv
// Scaling pipeline: sum * gain, divide by 100 * samples via reciprocal
// multiply and correction, saturate and apply cell presence. Uses osc_pkg.
module osc_scale #(
   parameter int SAMPLES_PER_CHANNEL = 16,
   parameter int CELL_CHANNELS       = 4,
   parameter int SUM_W               = 14,
   parameter int CH_W                = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  osc_pkg::tok_ctl_type         tok_in,
   output logic                         in_ready,
   input  logic [SUM_W-1:0]             sum_in,
   input  logic [CH_W-1:0]              ch_in,
   input  logic [osc_pkg::CAL_W-1:0]    gain_in,
   input  logic [osc_pkg::CAL_W-1:0]    level,
   output osc_pkg::tok_ctl_type         tok_out,
   input  logic                         out_ready,
   output logic [CH_W-1:0]              ch_out,
   output logic [osc_pkg::VALUE_W-1:0]  val_out
);

   localparam int PROD_W = SUM_W + osc_pkg::CAL_W;
   localparam int DIV    = osc_pkg::PERCENT * SAMPLES_PER_CHANNEL;
   localparam int Q_W    = PROD_W - $clog2(DIV) + 1;
   localparam int MUL_W  = PROD_W + Q_W;
   localparam int SAT_W  = (Q_W > osc_pkg::VALUE_W) ? Q_W : osc_pkg::VALUE_W;
   localparam longint unsigned RECIP_FULL = (64'd1 << PROD_W) / DIV;
   localparam logic [Q_W-1:0]  RECIP      = Q_W'(RECIP_FULL);

   osc_pkg::tok_ctl_type        tok2_ff, tok3_ff, tok4_ff;
   logic [PROD_W-1:0]           prod2_ff, prod3_ff;
   logic [Q_W-1:0]              qe3_ff;
   logic [CH_W-1:0]             ch2_ff, ch3_ff, ch4_ff;
   logic [osc_pkg::VALUE_W-1:0] val4_ff, val_calc;
   logic                        adv2, adv3, adv4;
   logic [MUL_W-1:0]            recip_prod;
   logic [PROD_W-1:0]           qd, rem;
   logic [Q_W-1:0]              q;

   assign adv4     = !tok4_ff.valid || out_ready;
   assign adv3     = !tok3_ff.valid || adv4;
   assign adv2     = !tok2_ff.valid || adv3;
   assign in_ready = adv2;

   assign recip_prod = MUL_W'(prod2_ff) * MUL_W'(RECIP);

   // estimate is low by at most one
   always_comb begin
      qd  = PROD_W'(qe3_ff) * PROD_W'(DIV);
      rem = prod3_ff - qd;
      q   = (rem >= PROD_W'(DIV)) ? qe3_ff + 1'b1 : qe3_ff;
      if (SAT_W'(q) > SAT_W'(osc_pkg::VALUE_MAX)) begin
         val_calc = osc_pkg::VALUE_MAX;
      end else begin
         val_calc = osc_pkg::VALUE_W'(q);
      end
      if (ch3_ff < CH_W'(CELL_CHANNELS) && val_calc < osc_pkg::VALUE_W'(level)) begin
         val_calc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok2_ff <= '0;
         tok3_ff <= '0;
         tok4_ff <= '0;
      end else begin
         if (adv2) begin
            tok2_ff <= tok_in;
         end
         if (adv3) begin
            tok3_ff <= tok2_ff;
         end
         if (adv4) begin
            tok4_ff <= tok3_ff;
         end
      end
      if (adv2) begin
         prod2_ff <= PROD_W'(sum_in) * PROD_W'(gain_in);
         ch2_ff   <= ch_in;
      end
      if (adv3) begin
         prod3_ff <= prod2_ff;
         qe3_ff   <= recip_prod[MUL_W-1:PROD_W];
         ch3_ff   <= ch2_ff;
      end
      if (adv4) begin
         val4_ff <= val_calc;
         ch4_ff  <= ch3_ff;
      end
   end

   assign tok_out = tok4_ff;
   assign ch_out  = ch4_ff;
   assign val_out = val4_ff;

endmodule

// File: hdl/osc_totals.sv
// Running totals memory with read-modify-write, valid bits for clear,
// sweep counter and the result output register. Uses osc_pkg.
module osc_totals #(
   parameter int NUM_CH = 7,
   parameter int CH_W   = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  osc_pkg::tok_ctl_type         tok_in,
   output logic                         in_ready,
   input  logic [CH_W-1:0]              ch_in,
   input  logic [osc_pkg::VALUE_W-1:0]  val_in,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [CH_W-1:0]              out_ch,
   output logic [osc_pkg::VALUE_W-1:0]  out_value,
   output logic [osc_pkg::TOTAL_W-1:0]  out_total,
   output logic                         out_done,
   output logic [osc_pkg::COUNT_W-1:0]  out_count
);

   logic [osc_pkg::TOTAL_W-1:0] mem [NUM_CH];
   logic [osc_pkg::TOTAL_W-1:0] rd_ff;
   osc_pkg::tok_ctl_type        t_tok_ff;
   logic [CH_W-1:0]             t_ch_ff;
   logic [osc_pkg::VALUE_W-1:0] t_val_ff;
   logic [NUM_CH-1:0]           vld_ff, vld_in;
   logic [osc_pkg::COUNT_W-1:0] sweeps_ff, sweeps_in;
   logic                        ov_ff, ov_in;
   logic [CH_W-1:0]             och_ff;
   logic [osc_pkg::VALUE_W-1:0] oval_ff;
   logic [osc_pkg::TOTAL_W-1:0] otot_ff;
   logic                        odone_ff;
   logic [osc_pkg::COUNT_W-1:0] ocnt_ff;
   logic                        adv_t, adv_o, leave, wr_en, done;
   logic [osc_pkg::TOTAL_W-1:0] base, total;

   assign adv_o    = !ov_ff || out_ready;
   assign adv_t    = !t_tok_ff.valid || adv_o;
   assign in_ready = adv_t;
   assign leave    = adv_o && t_tok_ff.valid;
   assign wr_en    = leave && t_tok_ff.kind == osc_pkg::TOK_RESULT;
   assign done     = (t_ch_ff == CH_W'(NUM_CH - 1));

   // never-written or cleared entries read as zero
   assign base  = vld_ff[t_ch_ff] ? rd_ff : '0;
   assign total = base + osc_pkg::TOTAL_W'(t_val_ff);

   always_comb begin
      vld_in    = vld_ff;
      sweeps_in = sweeps_ff;
      ov_in     = ov_ff && !out_ready;
      if (leave) begin
         if (t_tok_ff.kind == osc_pkg::TOK_CLEAR) begin
            vld_in    = '0;
            sweeps_in = '0;
         end else begin
            vld_in[t_ch_ff] = 1'b1;
            ov_in           = 1'b1;
            if (done) begin
               sweeps_in = sweeps_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_t) begin
         rd_ff <= mem[ch_in];
      end
      if (wr_en) begin
         mem[t_ch_ff] <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_tok_ff  <= '0;
         vld_ff    <= '0;
         sweeps_ff <= '0;
         ov_ff     <= 1'b0;
      end else begin
         if (adv_t) begin
            t_tok_ff <= tok_in;
         end
         vld_ff    <= vld_in;
         sweeps_ff <= sweeps_in;
         ov_ff     <= ov_in;
      end
      if (adv_t) begin
         t_ch_ff  <= ch_in;
         t_val_ff <= val_in;
      end
      if (wr_en) begin
         och_ff   <= t_ch_ff;
         oval_ff  <= t_val_ff;
         otot_ff  <= total;
         odone_ff <= done;
         ocnt_ff  <= sweeps_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_ch    = och_ff;
   assign out_value = oval_ff;
   assign out_total = otot_ff;
   assign out_done  = odone_ff;
   assign out_count = ocnt_ff;

endmodule

// File: hdl/oversampled_channel_scaler_core.sv
// Top level of the oversampled channel scaler: CSR block and pipeline.
// Depends on osc_pkg, osc_seq, osc_scale and osc_totals.
//
//   channel  direction  handshake           payload
//   req      in         req_tvalid/tready   tuser: action; tdata: sample
//   rsp      out        rsp_tvalid/tready   tuser: channel; tdata: value,
//                                           total, sweep count; tlast: sweep done
//   csr      in         APB, pready high    eight 16-bit registers at 4*i
//
// One item per cycle while req_tready is high. A channel result passes the
// accumulator, three scaling stages, totals read and output register after
// the item carrying its last sample. Synchronous reset; totals clear through
// per-entry valid bits, so there is no clearing pass. A stalled rsp backs up
// through the six-stage token pipeline; plain samples need no slot, completing
// samples and clears do, and req_tready drops only when the first stage is held.
module oversampled_channel_scaler_core #(
   parameter int SAMPLES_PER_CHANNEL = 16,
   parameter int CELL_CHANNELS       = 4,
   parameter int SAMPLE_BITS         = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample
   input  logic [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [19:0] value, [51:20] running_total,
                                    // [67:52] sweep_count
   output logic [2:0]  rsp_tuser,   // [2:0] channel
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NUM_CH     = CELL_CHANNELS + osc_pkg::EXTRA_CH;
   localparam int CH_W       = $clog2(NUM_CH);
   localparam int SAMPLE_MAX = (SAMPLE_BITS < osc_pkg::SAMPLE_W) ? (1 << SAMPLE_BITS) - 1
                                                                  : (1 << osc_pkg::SAMPLE_W) - 1;
   localparam int SUM_W      = $clog2(SAMPLES_PER_CHANNEL * SAMPLE_MAX + 1);

   logic [osc_pkg::NUM_CAL-1:0][osc_pkg::CAL_W-1:0] cal_ff, cal_in;
   logic [osc_pkg::CAL_W-1:0]   level_ff, level_in;
   osc_pkg::csr_reg_type        reg_sel;
   logic                        csr_wr;

   osc_pkg::tok_ctl_type        seq_tok, scl_tok;
   logic                        scl_ready, tot_ready;
   logic [SUM_W-1:0]            seq_sum;
   logic [CH_W-1:0]             seq_ch, scl_ch, out_ch;
   logic [osc_pkg::CAL_W-1:0]   seq_gain;
   logic [osc_pkg::VALUE_W-1:0] scl_val, out_value;
   logic [osc_pkg::TOTAL_W-1:0] out_total;
   logic [osc_pkg::COUNT_W-1:0] out_count;
   logic [CH_W+2:0]             ch_ext;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = osc_pkg::csr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cal_in   = cal_ff;
      level_in = level_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            osc_pkg::CSR_CELL_PRESENT: level_in = csr_pwdata[osc_pkg::CAL_W-1:0];
            default:                   cal_in[reg_sel] = csr_pwdata[osc_pkg::CAL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         osc_pkg::CSR_CELL_PRESENT: csr_prdata = 32'(level_ff);
         default:                   csr_prdata = 32'(cal_ff[reg_sel]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= {osc_pkg::NUM_CAL{osc_pkg::CAL_RESET}};
         level_ff <= osc_pkg::LEVEL_RESET;
      end else begin
         cal_ff   <= cal_in;
         level_ff <= level_in;
      end
   end

   osc_seq #(
      .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
      .CELL_CHANNELS       (CELL_CHANNELS),
      .SAMPLE_BITS         (SAMPLE_BITS),
      .SUM_W               (SUM_W),
      .CH_W                (CH_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (osc_pkg::action_type'(req_tuser[0])),
      .in_sample (req_tdata[osc_pkg::SAMPLE_W-1:0]),
      .cal       (cal_ff),
      .tok_out   (seq_tok),
      .tok_ready (scl_ready),
      .sum_out   (seq_sum),
      .ch_out    (seq_ch),
      .gain_out  (seq_gain)
   );

   osc_scale #(
      .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
      .CELL_CHANNELS       (CELL_CHANNELS),
      .SUM_W               (SUM_W),
      .CH_W                (CH_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .tok_in    (seq_tok),
      .in_ready  (scl_ready),
      .sum_in    (seq_sum),
      .ch_in     (seq_ch),
      .gain_in   (seq_gain),
      .level     (level_ff),
      .tok_out   (scl_tok),
      .out_ready (tot_ready),
      .ch_out    (scl_ch),
      .val_out   (scl_val)
   );

   osc_totals #(
      .NUM_CH (NUM_CH),
      .CH_W   (CH_W)
   ) u_totals (
      .clock     (clock),
      .reset     (reset),
      .tok_in    (scl_tok),
      .in_ready  (tot_ready),
      .ch_in     (scl_ch),
      .val_in    (scl_val),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ch    (out_ch),
      .out_value (out_value),
      .out_total (out_total),
      .out_done  (rsp_tlast),
      .out_count (out_count)
   );

   assign ch_ext    = (CH_W + 3)'(out_ch);
   assign rsp_tuser = ch_ext[2:0];
   assign rsp_tdata = {4'b0, out_count, out_total, out_value};

   // end of sweep is only ever flagged on the last channel
   a_done_last_ch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == 3'(NUM_CH - 1))
      else $error("sweep end flagged on wrong channel");

   // a non-zero cell value never lies below the presence level
   a_cell_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser < 3'(CELL_CHANNELS) && rsp_tdata[19:0] != '0
      |-> rsp_tdata[19:0] >= osc_pkg::VALUE_W'(level_ff))
      else $error("absent cell not forced to zero");

   // a clear is never lost: the pipeline head takes it at the next edge
   a_clear_taken: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == osc_pkg::ACT_CLEAR
      |=> seq_tok.valid && seq_tok.kind == osc_pkg::TOK_CLEAR)
      else $error("clear item not queued");

endmodule
